[src/hsf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hash slot finder package
// Shared types, codes and reset values for the linear-probe slot finder.
// ----------------------------------------------------------------------------
package hsf_pkg;

    localparam int SLOTS_DEFAULT = 1024;
    localparam int HASH_W        = 32;
    localparam int SIZE_W        = 11;
    localparam int HASH_SHIFT    = 5;
    localparam int SLOT_W        = 10;
    localparam int BYTE_W        = 8;
    localparam int BIT_CNT_W     = 5;

    localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = 11'd1024;
    localparam logic [HASH_W-1:0] HASH_SEED_RST  = 32'd5381;

    localparam logic REG_TABLE_SIZE = 1'b0;
    localparam logic REG_HASH_SEED  = 1'b1;

    localparam logic [1:0] ST_EMPTY     = 2'd0;
    localparam logic [1:0] ST_OCCUPIED  = 2'd1;
    localparam logic [1:0] ST_TOMBSTONE = 2'd2;

    typedef enum logic [1:0] {
        KIND_KEY  = 2'd0,
        KIND_OCC  = 2'd1,
        KIND_TOMB = 2'd2,
        KIND_CLR  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        RES_OK    = 2'd0,
        RES_FULL  = 2'd1,
        RES_RANGE = 2'd2
    } t_status;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] key_byte;
        logic              last_byte;
        logic [SLOT_W-1:0] slot;
    } t_in_beat;

    typedef struct packed {
        t_status           status;
        logic [SLOT_W-1:0] slot_index;
    } t_out_beat;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_HOME,
        S_PROBE_RD,
        S_PROBE_CHK
    } t_state;

    typedef struct packed {
        logic accept;
        logic clr_step;
        logic div_step;
        logic load_home;
        logic probe_rd;
        logic probe_adv;
        logic emit_ok;
        logic emit_full;
    } t_ctrl_cmd;

    typedef struct packed {
        logic clr_done;
        logic div_last;
        logic slot_free;
        logic lap_end;
        logic out_free;
    } t_dp_stat;

endpackage

[src/hsf_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hsf_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/hsf_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hash slot finder controller
// Sequences the clearing pass, the hash reduction and the linear probe.
// ----------------------------------------------------------------------------
module hsf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  hsf_pkg::t_kind    i_in_kind,
    input  logic              i_in_last,
    input  hsf_pkg::t_dp_stat i_stat,
    output hsf_pkg::t_ctrl_cmd o_cmd,
    output logic              o_in_stall
);
    import hsf_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   accept;
    logic   found;
    logic   full;

    assign accept = i_in_valid && (r_state == S_IDLE) && i_stat.out_free;
    assign found  = (r_state == S_PROBE_CHK) && i_stat.slot_free;
    assign full   = (r_state == S_PROBE_CHK) && !i_stat.slot_free && i_stat.lap_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_stat.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept && (i_in_kind == KIND_KEY) && i_in_last) n_state = S_DIV;
            end
            S_DIV: begin
                if (i_stat.div_last) n_state = S_HOME;
            end
            S_HOME: begin
                n_state = S_PROBE_RD;
            end
            S_PROBE_RD: begin
                n_state = S_PROBE_CHK;
            end
            S_PROBE_CHK: begin
                if (found || full) begin
                    if (i_stat.out_free) n_state = S_IDLE;
                end else begin
                    n_state = S_PROBE_RD;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.accept    = accept;
        o_cmd.clr_step  = (r_state == S_CLEAR);
        o_cmd.div_step  = (r_state == S_DIV);
        o_cmd.load_home = (r_state == S_HOME);
        o_cmd.probe_rd  = (r_state == S_PROBE_RD);
        o_cmd.probe_adv = (r_state == S_PROBE_CHK) && !i_stat.slot_free && !i_stat.lap_end;
        o_cmd.emit_ok   = found && i_stat.out_free;
        o_cmd.emit_full = full && i_stat.out_free;
        o_in_stall      = !((r_state == S_IDLE) && i_stat.out_free);
    end

endmodule

[src/hsf_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hash slot finder datapath
// Hash accumulator, bit-serial remainder unit, probe cursor, slot store
// and output register.
// ----------------------------------------------------------------------------
module hsf_datapath #(
    parameter int SLOTS = hsf_pkg::SLOTS_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  hsf_pkg::t_in_beat           i_in,
    input  logic                        i_out_stall,
    input  logic [hsf_pkg::SIZE_W-1:0]  i_table_size,
    input  logic [hsf_pkg::HASH_W-1:0]  i_hash_seed,
    input  hsf_pkg::t_ctrl_cmd          i_cmd,
    output hsf_pkg::t_dp_stat           o_stat,
    output logic                        o_out_valid,
    output hsf_pkg::t_out_beat          o_out
);
    import hsf_pkg::*;

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = (AW > SIZE_W) ? AW : SIZE_W;
    localparam logic [31:0]   SLOTS_U   = 32'(SLOTS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(SLOTS - 1);

    logic [AW-1:0]        r_clr_cnt;
    logic [HASH_W-1:0]    r_acc;
    logic                 r_kip;
    logic [HASH_W-1:0]    r_div;
    logic [SIZE_W-1:0]    r_rem;
    logic [BIT_CNT_W-1:0] r_bit;
    logic [CW-1:0]        r_cur;
    logic [CW-1:0]        r_home;
    logic                 r_out_valid;
    t_out_beat            r_out;

    logic [SIZE_W-1:0] ts_nz;
    logic [SIZE_W-1:0] size;
    logic [CW-1:0]     size_ext;
    logic [CW-1:0]     slot_ext;
    logic [HASH_W-1:0] h_base;
    logic [HASH_W-1:0] h_new;
    logic [SIZE_W:0]   rem_sh;
    logic [SIZE_W:0]   rem_sub;
    logic [CW-1:0]     cur_inc;
    logic [CW-1:0]     cur_nxt;
    logic              is_key;
    logic              upd_range;
    logic              upd_wr;
    logic [1:0]        upd_state;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [1:0]        ram_wdata;
    logic [1:0]        ram_rdata;

    always_comb begin
        ts_nz = (i_table_size == '0) ? SIZE_W'(1) : i_table_size;
        if (SLOTS_U < 32'(ts_nz)) begin
            size = SLOTS_U[SIZE_W-1:0];
        end else begin
            size = ts_nz;
        end
    end

    assign size_ext  = CW'(size);
    assign slot_ext  = CW'(i_in.slot);
    assign is_key    = (i_in.kind == KIND_KEY);
    assign upd_range = (slot_ext >= size_ext);
    assign upd_wr    = i_cmd.accept && !is_key && !upd_range;

    assign h_base = r_kip ? r_acc : i_hash_seed;
    assign h_new  = (h_base << HASH_SHIFT) + h_base + HASH_W'(i_in.key_byte);

    assign rem_sh  = {r_rem, r_div[HASH_W-1]};
    assign rem_sub = rem_sh - {1'b0, size};

    assign cur_inc = r_cur + CW'(1);
    assign cur_nxt = (cur_inc == size_ext) ? '0 : cur_inc;

    always_comb begin
        unique case (i_in.kind)
            KIND_OCC:  upd_state = ST_OCCUPIED;
            KIND_TOMB: upd_state = ST_TOMBSTONE;
            KIND_CLR:  upd_state = ST_EMPTY;
            KIND_KEY:  upd_state = ST_EMPTY;
        endcase
    end

    always_comb begin
        ram_we    = i_cmd.clr_step || upd_wr;
        ram_waddr = i_cmd.clr_step ? r_clr_cnt : slot_ext[AW-1:0];
        ram_wdata = i_cmd.clr_step ? ST_EMPTY : upd_state;
    end

    hsf_ram #(
        .WIDTH (2),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.probe_rd),
        .i_raddr (r_cur[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt   <= '0;
            r_acc       <= '0;
            r_kip       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr_cnt <= r_clr_cnt + AW'(1);
            end
            if (i_cmd.accept && is_key) begin
                r_acc <= h_new;
                r_kip <= !i_in.last_byte;
            end
            if ((i_cmd.accept && !is_key) || i_cmd.emit_ok || i_cmd.emit_full) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && is_key && i_in.last_byte) begin
            r_div <= h_new;
            r_rem <= '0;
            r_bit <= '0;
        end else if (i_cmd.div_step) begin
            r_div <= r_div << 1;
            r_bit <= r_bit + BIT_CNT_W'(1);
            if (rem_sh >= {1'b0, size}) begin
                r_rem <= rem_sub[SIZE_W-1:0];
            end else begin
                r_rem <= rem_sh[SIZE_W-1:0];
            end
        end
        if (i_cmd.load_home) begin
            r_cur  <= CW'(r_rem);
            r_home <= CW'(r_rem);
        end else if (i_cmd.probe_adv) begin
            r_cur <= cur_nxt;
        end
        if (i_cmd.accept && !is_key) begin
            r_out.status     <= upd_range ? RES_RANGE : RES_OK;
            r_out.slot_index <= i_in.slot;
        end else if (i_cmd.emit_ok) begin
            r_out.status     <= RES_OK;
            r_out.slot_index <= r_cur[SLOT_W-1:0];
        end else if (i_cmd.emit_full) begin
            r_out.status     <= RES_FULL;
            r_out.slot_index <= r_home[SLOT_W-1:0];
        end
    end

    always_comb begin
        o_stat.clr_done  = (r_clr_cnt == LAST_ADDR);
        o_stat.div_last  = (r_bit == {BIT_CNT_W{1'b1}});
        o_stat.slot_free = (ram_rdata == ST_EMPTY) || (ram_rdata == ST_TOMBSTONE);
        o_stat.lap_end   = (cur_nxt == r_home);
        o_stat.out_free  = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

[src/hash_slot_finder_linear_probe.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hash slot finder with linear probing
// Finds a free slot for a key by a DJB hash and an open-addressing probe,
// and updates slot states on request.
// ----------------------------------------------------------------------------
// Input beats carry one key byte or one slot update. Key bytes that are not
// the last are taken one per cycle while the output register is free and
// give no result. The last byte gives one result after a bit-serial
// remainder over the 32 hash bits, a step to load the home slot and, for each
// slot probed (up to the live table size), a registered read of the slot
// store then a check, while the input is stalled. An update beat's result
// appears in the cycle after it is taken.
// Results sit in an output register; a new beat is taken while a result
// waits only if the receiver takes that result in the same cycle, so a
// stalled receiver holds the output beat and stalls the input.
// After reset the slot store is swept to empty, one slot per cycle, over all
// SLOTS slots, while the input is stalled; register writes are still taken.
// Registers: table_size at byte address 0, hash_seed at byte address 4.
// ----------------------------------------------------------------------------
module hash_slot_finder_linear_probe #(
    parameter int SLOTS = hsf_pkg::SLOTS_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  hsf_pkg::t_in_beat  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output hsf_pkg::t_out_beat o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import hsf_pkg::*;

    logic [SIZE_W-1:0] r_table_size;
    logic [HASH_W-1:0] r_hash_seed;
    logic              cfg_wr;
    t_ctrl_cmd         cmd;
    t_dp_stat          stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= TABLE_SIZE_RST;
            r_hash_seed  <= HASH_SEED_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_TABLE_SIZE: r_table_size <= pwdata[SIZE_W-1:0];
                REG_HASH_SEED:  r_hash_seed  <= pwdata;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_TABLE_SIZE: prdata = 32'(r_table_size);
            REG_HASH_SEED:  prdata = r_hash_seed;
        endcase
    end

    hsf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_kind  (i_in.kind),
        .i_in_last  (i_in.last_byte),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    hsf_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_out_stall  (i_out_stall),
        .i_table_size (r_table_size),
        .i_hash_seed  (r_hash_seed),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_out_valid  (o_out_valid),
        .o_out        (o_out)
    );

endmodule

[src/hsf_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hash slot finder checker
// Port-level properties of the slot finder, bound to the top level.
// ----------------------------------------------------------------------------
module hsf_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input hsf_pkg::t_in_beat  i_in,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input hsf_pkg::t_out_beat o_out
);
    import hsf_pkg::*;

    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("output beat changed while stalled");

    a_update_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_in.kind != KIND_KEY) |=> o_out_valid)
        else $error("update beat gave no result");

    a_mid_key_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_in.kind == KIND_KEY) && !i_in.last_byte && !o_out_valid
        |=> !o_out_valid)
        else $error("result appeared for a key byte that is not the last");

    a_last_byte_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_in.kind == KIND_KEY) && i_in.last_byte |=> o_in_stall)
        else $error("input taken during a probe");

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall && !o_out_valid)
        else $error("block not stalled and empty after reset");

endmodule

bind hash_slot_finder_linear_probe hsf_checker u_checker (.*);

[bench/hash_slot_finder_linear_probe_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hash slot finder testbench
// Streams keys and slot updates into the linear-probe slot finder with random
// gaps on both sides. A behavioural copy of the hash, the modulo, the probe
// and the slot store predicts every result beat. Each result is checked field
// by field against the oldest prediction, across several register settings.
// ----------------------------------------------------------------------------
module hash_slot_finder_linear_probe_tb;
    import hsf_pkg::*;

    class slot_search_board;
        logic [SIZE_W-1:0] table_size;
        logic [HASH_W-1:0] hash_seed;
        logic [HASH_W-1:0] hash_acc;
        bit                key_open;
        logic [1:0]        slot_state [SLOTS_DEFAULT];
        t_out_beat         slot_answers [$];
        int                fail_count;

        function new();
            table_size = TABLE_SIZE_RST;
            hash_seed  = HASH_SEED_RST;
            hash_acc   = '0;
            key_open   = 1'b0;
            fail_count = 0;
            foreach (slot_state[i]) slot_state[i] = ST_EMPTY;
        endfunction

        function void write_reg(logic idx, logic [31:0] value);
            if (idx == REG_TABLE_SIZE) begin
                table_size = value[SIZE_W-1:0];
            end else if (idx == REG_HASH_SEED) begin
                hash_seed = value;
            end
        endfunction

        function int unsigned live_slots();
            int unsigned n;
            n = 32'(table_size);
            if (n == 0) n = 1;
            if (n > SLOTS_DEFAULT) n = SLOTS_DEFAULT;
            return n;
        endfunction

        function int pending();
            return slot_answers.size();
        endfunction

        function void push_answer(t_status st, int unsigned idx);
            t_out_beat r;
            r.status     = st;
            r.slot_index = idx[SLOT_W-1:0];
            slot_answers.push_back(r);
        endfunction

        function void take_in_beat(t_in_beat b);
            int unsigned       size;
            int unsigned       home;
            int unsigned       cur;
            logic [HASH_W-1:0] h;
            size = live_slots();
            if (b.kind == KIND_KEY) begin
                h = key_open ? hash_acc : hash_seed;
                h = (h << HASH_SHIFT) + h + HASH_W'(b.key_byte);
                hash_acc = h;
                key_open = !b.last_byte;
                if (!b.last_byte) return;
                home = h % size;
                cur  = home;
                while (slot_state[cur[SLOT_W-1:0]] != ST_EMPTY &&
                       slot_state[cur[SLOT_W-1:0]] != ST_TOMBSTONE) begin
                    cur = (cur + 1 == size) ? 0 : cur + 1;
                    if (cur == home) begin
                        push_answer(RES_FULL, home);
                        return;
                    end
                end
                push_answer(RES_OK, cur);
            end else if (32'(b.slot) >= size) begin
                push_answer(RES_RANGE, 32'(b.slot));
            end else begin
                case (b.kind)
                    KIND_OCC: begin
                        slot_state[b.slot] = ST_OCCUPIED;
                    end
                    KIND_TOMB: begin
                        slot_state[b.slot] = ST_TOMBSTONE;
                    end
                    default: begin
                        slot_state[b.slot] = ST_EMPTY;
                    end
                endcase
                push_answer(RES_OK, 32'(b.slot));
            end
        endfunction

        function void report(string msg);
            if (fail_count < 10) $display("%0t: %s", $time, msg);
            fail_count++;
        endfunction

        function void check_out_beat(t_out_beat got);
            t_out_beat want;
            if (slot_answers.size() == 0) begin
                report($sformatf("unexpected result beat: status %0d slot %0d",
                                 got.status, got.slot_index));
                return;
            end
            want = slot_answers.pop_front();
            if (got.status !== want.status || got.slot_index !== want.slot_index) begin
                report($sformatf("result mismatch: expected status %0d slot %0d, got status %0d slot %0d",
                                 want.status, want.slot_index, got.status, got.slot_index));
            end
        endfunction
    endclass

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 10;
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 20000;
    localparam int PHASE_ITEMS   = 115;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    t_in_beat    in_beat   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out_beat   out_beat;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int sent_items    = 0;
    int idle_cycles   = 0;

    slot_search_board board;

    hash_slot_finder_linear_probe i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_beat),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) board.check_out_beat(out_beat);
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("hash_slot_finder_linear_probe test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_beat(t_in_beat b);
        bit taken;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        do begin
            @(posedge clk);
            taken = !in_stall;
            if (taken) board.take_in_beat(b);
            @(negedge clk);
        end while (!taken);
        sent_items++;
    endtask

    task automatic send_byte(logic [BYTE_W-1:0] value, logic last);
        t_in_beat b;
        b.kind      = KIND_KEY;
        b.key_byte  = value;
        b.last_byte = last;
        b.slot      = SLOT_W'($urandom);
        send_beat(b);
    endtask

    task automatic send_update(t_kind k, logic [SLOT_W-1:0] s);
        t_in_beat b;
        b.kind      = k;
        b.key_byte  = BYTE_W'($urandom);
        b.last_byte = 1'($urandom);
        b.slot      = s;
        send_beat(b);
    endtask

    task automatic send_random_update();
        int unsigned       r;
        t_kind             k;
        logic [SLOT_W-1:0] s;
        r = $urandom_range(99);
        k = (r < 50) ? KIND_OCC : (r < 75) ? KIND_TOMB : KIND_CLR;
        if ($urandom_range(9) == 0) begin
            s = SLOT_W'($urandom);
        end else begin
            s = SLOT_W'($urandom_range(board.live_slots() - 1, 0));
        end
        send_update(k, s);
    endtask

    task automatic send_key(int unsigned len);
        bit last;
        for (int unsigned i = 0; i < len; i++) begin
            last = (i == len - 1);
            send_byte(BYTE_W'($urandom), last);
            if (!last && $urandom_range(9) == 0) send_random_update();
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] value);
        logic [31:0] want;
        want = (idx == REG_TABLE_SIZE) ? 32'(value[SIZE_W-1:0]) : value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do begin
            @(posedge clk);
        end while (!pready);
        board.write_reg(idx, value);
        @(negedge clk);
        if (prdata !== want) begin
            board.report($sformatf("register read-back mismatch: expected %0h, got %0h",
                                   want, prdata));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic run_phase(logic [SIZE_W-1:0] size, logic [HASH_W-1:0] seed,
                             int send_pct, int recv_pct, int items);
        int target;
        write_reg(REG_TABLE_SIZE, 32'(size));
        write_reg(REG_HASH_SEED, seed);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        target = sent_items + items;
        while (sent_items < target) begin
            if ($urandom_range(99) < 60) begin
                send_key($urandom_range(5, 1));
            end else begin
                send_random_update();
            end
        end
        drain();
    endtask

    initial begin
        board = new();
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_update(KIND_OCC, 10'd0);
        send_update(KIND_OCC, 10'h3FF);
        send_update(KIND_TOMB, 10'h3FF);
        send_update(KIND_CLR, 10'd0);
        drain();

        // Fill a small table, probe it full, then free one slot by tombstone.
        write_reg(REG_TABLE_SIZE, 32'd4);
        for (int i = 0; i < 4; i++) send_update(KIND_OCC, SLOT_W'(i));
        send_byte(8'h5A, 1'b1);
        send_update(KIND_TOMB, 10'd2);
        send_byte(8'hA5, 1'b1);
        send_update(KIND_CLR, 10'd4);
        send_update(KIND_OCC, 10'h3FF);
        drain();

        write_reg(REG_TABLE_SIZE, 32'd0);
        send_byte(8'h33, 1'b1);
        send_update(KIND_CLR, 10'd0);
        send_byte(8'h33, 1'b1);
        drain();

        // New settings between the bytes of one key.
        write_reg(REG_TABLE_SIZE, 32'h7FF);
        write_reg(REG_HASH_SEED, 32'hFFFF_FFFF);
        send_byte(8'hFF, 1'b0);
        drain();
        write_reg(REG_HASH_SEED, 32'd0);
        write_reg(REG_TABLE_SIZE, 32'd3);
        send_byte(8'h7E, 1'b1);
        drain();

        run_phase(11'd5, $urandom, 35, 49, PHASE_ITEMS);
        run_phase(11'd1024, 32'd0, 35, 49, PHASE_ITEMS);
        run_phase(11'h7FF, 32'hFFFF_FFFF, 49, 35, PHASE_ITEMS);
        run_phase(11'd0, $urandom, 49, 35, PHASE_ITEMS);
        run_phase(SIZE_W'($urandom_range(64, 2)), $urandom, 0, 0, PHASE_ITEMS);
        run_phase(11'd1, HASH_SEED_RST, 0, 0, PHASE_ITEMS);

        if (board.fail_count == 0 && board.pending() == 0) begin
            $display("hash_slot_finder_linear_probe test passed");
        end else begin
            $display("hash_slot_finder_linear_probe test failed");
        end
        $finish;
    end

endmodule
